// ===== design/htd_pkg.sv =====
// Package for the hit-target debounce controller.
// Holds field widths, command and LED codes, register indexes and the item structs.
// No dependencies; every other design file refers to it by scoped names.
package htd_pkg;

    localparam int RAW_W   = 9;
    localparam int KEY_W   = 4;
    localparam int PHASE_W = 4;
    localparam int DB_W    = 8;
    localparam int FLOW_W  = 16;
    localparam int LED_W   = 3;
    localparam int ACT_W   = 2;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 16;

    // Widened button vector: bits above RAW_W read as zero (pressed).
    localparam int EXT_W   = 16;

    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE      = 2'd0,
        ACT_ON        = 2'd1,
        ACT_ALL_OFF   = 2'd2,
        ACT_LOCAL_OFF = 2'd3
    } t_action;

    typedef enum logic [LED_W-1:0] {
        LED_NONE   = 3'd0,
        LED_ACTIVE = 3'd1,
        LED_IDLE   = 3'd2,
        LED_OFF    = 3'd3,
        LED_HIT    = 3'd4
    } t_led;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 1'd0,
        CFG_FLOW_PERIOD    = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [RAW_W-1:0] raw_buttons;
        logic             link_active;
        logic [ACT_W-1:0] action;
        logic             command_mode;
    } t_item;

    typedef struct packed {
        logic [LED_W-1:0]   led_command;
        logic [PHASE_W-1:0] led_phase;
        logic [KEY_W-1:0]   led_key;
        logic               hit_event;
        logic               hit_latched;
        logic               current_mode;
        logic [KEY_W-1:0]   debounced_key;
    } t_result;

endpackage

// ===== design/htd_if.sv =====
// Handshake interfaces for the tick input, result output and configuration channels.
// Depends on htd_pkg for field widths.
interface htd_item_if;
    logic                            valid;
    logic                            ready;
    logic [htd_pkg::RAW_W-1:0]       raw_buttons;
    logic                            link_active;
    logic [htd_pkg::ACT_W-1:0]       action;
    logic                            command_mode;

    modport source (output valid, raw_buttons, link_active, action, command_mode,
                    input ready);
    modport sink   (input valid, raw_buttons, link_active, action, command_mode,
                    output ready);
endinterface

interface htd_result_if;
    logic                            valid;
    logic                            ready;
    logic [htd_pkg::LED_W-1:0]       led_command;
    logic [htd_pkg::PHASE_W-1:0]     led_phase;
    logic [htd_pkg::KEY_W-1:0]       led_key;
    logic                            hit_event;
    logic                            hit_latched;
    logic                            current_mode;
    logic [htd_pkg::KEY_W-1:0]       debounced_key;

    modport source (output valid, led_command, led_phase, led_key, hit_event,
                    hit_latched, current_mode, debounced_key, input ready);
    modport sink   (input valid, led_command, led_phase, led_key, hit_event,
                    hit_latched, current_mode, debounced_key, output ready);
endinterface

interface htd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [htd_pkg::CIDX_W-1:0]      index;
    logic [htd_pkg::CDATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/htd_debounce.sv =====
// Key priority encoder and debounce filter.
// Holds candidate key, stable count and stable key; depends on htd_pkg.
module htd_debounce #(
    parameter int NUM_BUTTONS = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [htd_pkg::RAW_W-1:0]   i_raw_buttons,
    input  logic [htd_pkg::DB_W-1:0]    i_debounce_ticks,
    output logic [htd_pkg::KEY_W-1:0]   o_stable_key_next
);

    logic [htd_pkg::KEY_W-1:0]  r_candidate_key, n_candidate_key;
    logic [htd_pkg::DB_W-1:0]   r_stable_count, n_stable_count;
    logic [htd_pkg::KEY_W-1:0]  r_stable_key, n_stable_key;
    logic [htd_pkg::EXT_W-1:0]  w_ext;
    logic [htd_pkg::KEY_W-1:0]  w_raw_key;

    assign w_ext = {{(htd_pkg::EXT_W - htd_pkg::RAW_W){1'b0}}, i_raw_buttons};

    // Scan from the top so the lowest pressed button wins.
    always_comb begin
        w_raw_key = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (!w_ext[i]) begin
                w_raw_key = htd_pkg::KEY_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_candidate_key = r_candidate_key;
        n_stable_count  = r_stable_count;
        n_stable_key    = r_stable_key;
        if (w_raw_key != r_candidate_key) begin
            n_candidate_key = w_raw_key;
            n_stable_count  = '0;
        end else begin
            if (r_stable_count < i_debounce_ticks) begin
                n_stable_count = r_stable_count + 1'b1;
            end
            if (n_stable_count >= i_debounce_ticks) begin
                n_stable_key = r_candidate_key;
            end
        end
    end

    assign o_stable_key_next = n_stable_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate_key <= '0;
            r_stable_count  <= '0;
            r_stable_key    <= '0;
        end else if (i_advance) begin
            r_candidate_key <= n_candidate_key;
            r_stable_count  <= n_stable_count;
            r_stable_key    <= n_stable_key;
        end
    end

endmodule

// ===== design/htd_target_ctrl.sv =====
// Target control: commands, hit detection, flow timer and LED phase.
// Holds press lock, hit latch, mode, phase and flow timer; depends on htd_pkg.
module htd_target_ctrl #(
    parameter int PHASE_COUNT = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  htd_pkg::t_item              i_item,
    input  logic [htd_pkg::KEY_W-1:0]   i_stable_key,
    input  logic [htd_pkg::FLOW_W-1:0]  i_flow_period,
    output htd_pkg::t_result            o_result
);

    localparam logic [htd_pkg::PHASE_W-1:0] PHASE_LAST = htd_pkg::PHASE_W'(PHASE_COUNT - 1);

    logic                         r_press_lock, n_press_lock;
    logic                         r_hit_held, n_hit_held;
    logic                         r_mode, n_mode;
    logic [htd_pkg::PHASE_W-1:0]  r_phase, n_phase;
    logic [htd_pkg::FLOW_W-1:0]   r_flow_elapsed, n_flow_elapsed;
    htd_pkg::t_led                w_led;
    logic                         w_hit_event;

    always_comb begin
        n_press_lock   = r_press_lock;
        n_hit_held     = r_hit_held;
        n_mode         = r_mode;
        n_phase        = r_phase;
        n_flow_elapsed = (r_flow_elapsed != htd_pkg::FLOW_MAX) ? r_flow_elapsed + 1'b1
                                                               : r_flow_elapsed;
        w_led          = htd_pkg::LED_NONE;
        w_hit_event    = 1'b0;

        case (htd_pkg::t_action'(i_item.action))
            htd_pkg::ACT_ON: begin
                n_mode         = i_item.command_mode;
                n_hit_held     = 1'b0;
                n_phase        = '0;
                n_flow_elapsed = '0;
                w_led          = htd_pkg::LED_ACTIVE;
            end
            htd_pkg::ACT_ALL_OFF: begin
                n_hit_held = 1'b0;
                w_led      = htd_pkg::LED_IDLE;
            end
            htd_pkg::ACT_LOCAL_OFF: begin
                // Small-mode hit stays latched with no order shown.
                if (r_hit_held && r_mode) begin
                    n_hit_held = 1'b0;
                    w_led      = htd_pkg::LED_OFF;
                end else if (!r_hit_held) begin
                    w_led = htd_pkg::LED_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (i_stable_key == '0) begin
            n_press_lock = 1'b0;
        end

        if (i_item.link_active && !n_hit_held && !n_press_lock && i_stable_key != '0) begin
            n_press_lock = 1'b1;
            n_hit_held   = 1'b1;
            w_hit_event  = 1'b1;
            w_led        = n_mode ? htd_pkg::LED_OFF : htd_pkg::LED_HIT;
        end

        if (i_item.link_active && !n_hit_held && n_flow_elapsed >= i_flow_period) begin
            n_flow_elapsed = '0;
            n_phase        = (n_phase == '0) ? PHASE_LAST : n_phase - 1'b1;
            w_led          = htd_pkg::LED_ACTIVE;
        end
    end

    always_comb begin
        o_result.led_command   = w_led;
        o_result.led_phase     = n_phase;
        o_result.led_key       = (w_led == htd_pkg::LED_HIT) ? i_stable_key : '0;
        o_result.hit_event     = w_hit_event;
        o_result.hit_latched   = n_hit_held;
        o_result.current_mode  = n_mode;
        o_result.debounced_key = i_stable_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_lock   <= 1'b0;
            r_hit_held     <= 1'b0;
            r_mode         <= 1'b0;
            r_phase        <= '0;
            r_flow_elapsed <= '0;
        end else if (i_advance) begin
            r_press_lock   <= n_press_lock;
            r_hit_held     <= n_hit_held;
            r_mode         <= n_mode;
            r_phase        <= n_phase;
            r_flow_elapsed <= n_flow_elapsed;
        end
    end

endmodule

// ===== design/hit_target_debounce_controller.sv =====
// Top level of the hit-target debounce controller.
// Depends on htd_pkg, htd_if.sv, htd_debounce and htd_target_ctrl.
//
// Usage:
//   i_item   - one transfer per 1 ms tick: nine active-low buttons, link flag,
//              command (none, on, all off, local off) and the mode of the on command.
//   o_result - one transfer per tick: LED order, phase, hit key, hit event,
//              hit-latched flag, current mode and debounced key.
//   i_cfg    - register writes: index 0 debounce ticks (data[7:0]), index 1 flow
//              period in ticks (data[15:0]). Always ready; write only while idle.
// Pipeline: a tick transfer is captured in the input register, then loaded into
//   the result register fed by one pass of the key and target logic, where the
//   result is held until o_result takes it.
// Throughput: one tick per cycle while o_result is taken; the target state
//   updates in one pass of the logic, so back-to-back ticks keep the pipeline full.
// Reset (synchronous, active low): all target and debounce state cleared, small
//   mode, debounce ticks 20, flow period 100, both stages empty.
// Stall: while o_result is held, the input stage fills and then drops ready;
//   no tick is lost and the pending result holds steady.
module hit_target_debounce_controller #(
    parameter int NUM_BUTTONS = 9,
    parameter int PHASE_COUNT = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    htd_item_if.sink        i_item,
    htd_result_if.source    o_result,
    htd_cfg_if.sink         i_cfg
);

    logic [htd_pkg::DB_W-1:0]    r_debounce_ticks;
    logic [htd_pkg::FLOW_W-1:0]  r_flow_period;

    logic                        r_s1_valid;
    htd_pkg::t_item              r_s1_item;
    logic                        r_out_valid;
    htd_pkg::t_result            r_out;

    logic                        w_advance;
    logic [htd_pkg::KEY_W-1:0]   w_stable_key;
    htd_pkg::t_result            w_result;

    // Advance the held tick when the result register is free or being drained.
    assign w_advance    = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= htd_pkg::DB_W'(20);
            r_flow_period    <= htd_pkg::FLOW_W'(100);
        end else if (i_cfg.valid) begin
            case (htd_pkg::t_cfg_idx'(i_cfg.index))
                htd_pkg::CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg.data[htd_pkg::DB_W-1:0];
                htd_pkg::CFG_FLOW_PERIOD:    r_flow_period    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Input register: capture a tick on transfer, drop valid once it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1_item.raw_buttons  <= i_item.raw_buttons;
            r_s1_item.link_active  <= i_item.link_active;
            r_s1_item.action       <= i_item.action;
            r_s1_item.command_mode <= i_item.command_mode;
        end
    end

    htd_debounce #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_debounce (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (w_advance),
        .i_raw_buttons     (r_s1_item.raw_buttons),
        .i_debounce_ticks  (r_debounce_ticks),
        .o_stable_key_next (w_stable_key)
    );

    htd_target_ctrl #(
        .PHASE_COUNT (PHASE_COUNT)
    ) u_target_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_item        (r_s1_item),
        .i_stable_key  (w_stable_key),
        .i_flow_period (r_flow_period),
        .o_result      (w_result)
    );

    // Result register: load on advance, clear valid when taken with nothing new.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.led_command   = r_out.led_command;
    assign o_result.led_phase     = r_out.led_phase;
    assign o_result.led_key       = r_out.led_key;
    assign o_result.hit_event     = r_out.hit_event;
    assign o_result.hit_latched   = r_out.hit_latched;
    assign o_result.current_mode  = r_out.current_mode;
    assign o_result.debounced_key = r_out.debounced_key;

    // A reported hit always leaves the target latched.
    a_hit_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit_event) |-> r_out.hit_latched)
        else $error("hit event without hit latched");

    // The hit key is shown only with the hit order and matches the debounced key.
    a_key_with_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.led_key != '0) |->
            (r_out.led_command == htd_pkg::LED_HIT && r_out.led_key == r_out.debounced_key))
        else $error("led key outside hit order");

    // Phase stays within the rotation.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out.led_phase} < (htd_pkg::PHASE_W + 1)'(PHASE_COUNT)))
        else $error("phase out of range");

    // A tick waiting in the input register moves on as soon as the output frees up.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("held tick failed to advance");

endmodule
